// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define NEA_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion on the usual clock and reset names.
`define NEA_ASSERT(label, prop, msg) \
   `NEA_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// File: rtl/core/nea_pkg.sv
// Shared types and constants of the normal equation accumulator.
// Depends on nothing; imported by every module of the block except nea_ram.
`timescale 1ns / 1ps
`default_nettype none

package nea_pkg;

   localparam int MAX_TERMS_DEFAULT   = 8;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int ACC_BITS_DEFAULT    = 48;

   // Fixed field layout of an input item
   localparam int REG_COUNT     = 8;
   localparam int CMD_BITS      = 2;
   localparam int READ_ROW_BITS = 3;
   localparam int READ_COL_BITS = 4;
   localparam int TERMS_BITS    = 4;

   localparam logic [READ_COL_BITS-1:0] MOMENT_COL  = 4'd8;
   localparam logic [TERMS_BITS-1:0]    TERMS_RESET = 4'd8;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD  = 2'd0,
      CMD_SUB  = 2'd1,
      CMD_READ = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SWEEP,
      ST_DRAIN,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                     capture;
      logic                     issue;
      logic                     update;
      logic                     take_read;
      logic                     load_out;
      logic [READ_ROW_BITS-1:0] row;
      logic [READ_COL_BITS-1:0] col;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] kind;
      logic                out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// File: rtl/core/normal_equation_accumulator.sv
// Top level of the normal equation accumulator: controller plus datapath.
// Depends on nea_pkg, nea_ctrl, nea_dp (and through it nea_ram).
`timescale 1ns / 1ps
`default_nettype none

//  channel | direction | handshake              | carries
//  --------+-----------+------------------------+--------------------------------------
//  req     | in        | req_tvalid/req_tready  | command, observation row, read index
//  rsp     | out       | rsp_tvalid/rsp_tready  | read value, sticky overflow flag
//  csr     | in        | csr_valid/csr_ready    | active_terms
//
//  Add or subtract: every Gram and moment entry is swept one after another through the single
//  multiplier and the one RAM write port before the result is offered.
//  Read: one RAM read of the indexed entry. Unused command: no RAM access.
//  Reset clears the entry valid bits at once; no clearing pass, an item can follow reset.
//  The next item is accepted while a result waits in the output register; a finished
//  item holds in the controller until that register is free.

module normal_equation_accumulator
   import nea_pkg::*;
#(
   parameter  int MAX_TERMS     = MAX_TERMS_DEFAULT,
   parameter  int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT,
   parameter  int ACC_BITS      = ACC_BITS_DEFAULT,
   localparam int REQ_DATA_BITS =
      ((REG_COUNT * SAMPLE_BITS + SAMPLE_BITS + READ_ROW_BITS + READ_COL_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((ACC_BITS + 7) / 8) * 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // regressor_0..regressor_7, target, read_row, read_col, zero padding
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // command
   input  wire logic [CMD_BITS-1:0]      req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // read_value, zero padding
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   // overflow
   output logic      [0:0]               rsp_tuser,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [TERMS_BITS-1:0]    csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // the term count register always takes a write
   assign csr_ready = 1'b1;

   nea_ctrl #(
      .MAX_TERMS (MAX_TERMS)
   ) u_nea_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nea_dp #(
      .MAX_TERMS   (MAX_TERMS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_nea_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data)
   );

endmodule

`default_nettype wire

// File: rtl/core/nea_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module nea_ram #(
   parameter  int WIDTH     = 8,
   parameter  int DEPTH     = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/nea_ctrl.sv
// Controller of the normal equation accumulator: sequences the entry sweep and reads.
// Depends on nea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nea_ctrl
   import nea_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   localparam logic [READ_ROW_BITS-1:0] ROW_LAST = READ_ROW_BITS'(MAX_TERMS - 1);
   localparam logic [READ_COL_BITS-1:0] COL_LAST = READ_COL_BITS'(MAX_TERMS - 1);

   state_type                state_ff, state_in;
   logic [READ_ROW_BITS-1:0] row_ff, row_in;
   logic [READ_COL_BITS-1:0] col_ff, col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.row    = row_ff;
      cmd.col    = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            row_in     = '0;
            col_in     = '0;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.kind) inside
               CMD_ADD, CMD_SUB: state_in = ST_SWEEP;
               CMD_READ:         state_in = ST_RD_ISSUE;
               default:          state_in = ST_FINISH;
            endcase
         end
         ST_SWEEP: begin
            cmd.issue  = 1'b1;
            cmd.update = 1'b1;
            // column order: Gram columns, then the moment entry of the row
            if (col_ff == MOMENT_COL) begin
               col_in = '0;
               if (row_ff == ROW_LAST) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else if (col_ff == COL_LAST) begin
               col_in = MOMENT_COL;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_RD_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            cmd.take_read = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/nea_dp.sv
// Datapath of the normal equation accumulator: operand lines, one multiplier,
// saturating accumulate into the entry RAM, output register. Depends on nea_pkg, nea_ram.
`timescale 1ns / 1ps
`default_nettype none

module nea_dp
   import nea_pkg::*;
#(
   parameter  int MAX_TERMS     = MAX_TERMS_DEFAULT,
   parameter  int SAMPLE_BITS   = SAMPLE_BITS_DEFAULT,
   parameter  int ACC_BITS      = ACC_BITS_DEFAULT,
   localparam int REQ_DATA_BITS =
      ((REG_COUNT * SAMPLE_BITS + SAMPLE_BITS + READ_ROW_BITS + READ_COL_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((ACC_BITS + 7) / 8) * 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_cmd_type             cmd,
   output ctrl_status_type               status,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [CMD_BITS-1:0]      req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic      [0:0]               rsp_tuser,
   input  wire logic                     csr_valid,
   input  wire logic [TERMS_BITS-1:0]    csr_data
);

   localparam int DEPTH      = MAX_TERMS * MAX_TERMS + MAX_TERMS;
   localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_BITS  = 2 * SAMPLE_BITS;
   localparam int SUM_BITS   = ((ACC_BITS > PROD_BITS) ? ACC_BITS : PROD_BITS) + 1;
   localparam int TARGET_LSB = REG_COUNT * SAMPLE_BITS;
   localparam int ROW_LSB    = TARGET_LSB + SAMPLE_BITS;
   localparam int COL_LSB    = ROW_LSB + READ_ROW_BITS;

   logic [TERMS_BITS-1:0]           active_ff;
   logic [CMD_BITS-1:0]             kind_ff;
   logic signed [SAMPLE_BITS-1:0]   target_ff;
   logic signed [SAMPLE_BITS-1:0]   row_line_ff [MAX_TERMS];
   logic signed [SAMPLE_BITS-1:0]   col_line_ff [MAX_TERMS];
   logic [READ_ROW_BITS-1:0]        rd_row_ff;
   logic [READ_COL_BITS-1:0]        rd_col_ff;
   logic signed [PROD_BITS-1:0]     prod_ff;
   logic [ADDR_BITS-1:0]            wr_addr_ff;
   logic                            wr_pend_ff;
   logic                            rd_vld_ff;
   logic [DEPTH-1:0]                valid_ff;
   logic                            ovf_ff;
   logic signed [ACC_BITS-1:0]      value_ff;
   logic                            rsp_valid_ff;
   logic signed [ACC_BITS-1:0]      rsp_value_ff;
   logic                            rsp_ovf_ff;

   logic [TERMS_BITS-1:0]           eff_terms;
   logic [READ_ROW_BITS-1:0]        idx_row;
   logic [READ_COL_BITS-1:0]        idx_col;
   logic                            is_gram;
   logic                            is_mom;
   logic                            in_range;
   logic [ADDR_BITS-1:0]            addr;
   logic signed [SAMPLE_BITS-1:0]   mult_b;
   logic signed [PROD_BITS-1:0]     prod;
   logic [ACC_BITS-1:0]             ram_rdata;
   logic signed [ACC_BITS-1:0]      acc;
   logic signed [SUM_BITS-1:0]      sum;
   logic [SUM_BITS-ACC_BITS:0]      sum_top;
   logic                            fits;
   logic [ACC_BITS-1:0]             wr_data;

   assign eff_terms = (active_ff > TERMS_BITS'(MAX_TERMS)) ? TERMS_BITS'(MAX_TERMS) : active_ff;

   // sweep entries come from the controller, a read uses the captured indices
   assign idx_row  = cmd.update ? cmd.row : rd_row_ff;
   assign idx_col  = cmd.update ? cmd.col : rd_col_ff;
   assign is_gram  = idx_col < READ_COL_BITS'(MAX_TERMS);
   assign is_mom   = idx_col == MOMENT_COL;
   assign in_range = ({1'b0, idx_row} < (READ_ROW_BITS + 1)'(MAX_TERMS)) && (is_gram || is_mom);

   always_comb begin
      if (!in_range) begin
         addr = '0;
      end else if (is_gram) begin
         addr = ADDR_BITS'(int'(idx_row) * MAX_TERMS + int'(idx_col));
      end else begin
         addr = ADDR_BITS'(MAX_TERMS * MAX_TERMS + int'(idx_row));
      end
   end

   assign mult_b = is_mom ? target_ff : col_line_ff[0];
   assign prod   = row_line_ff[0] * mult_b;

   // saturating accumulate; entries never written read as zero
   assign acc     = rd_vld_ff ? signed'(ram_rdata) : '0;
   assign sum     = (kind_ff == CMD_SUB) ? (SUM_BITS'(acc) - SUM_BITS'(prod_ff))
                                         : (SUM_BITS'(acc) + SUM_BITS'(prod_ff));
   assign sum_top = sum[SUM_BITS-1:ACC_BITS-1];
   assign fits    = (&sum_top) || !(|sum_top);
   assign wr_data = fits ? sum[ACC_BITS-1:0]
                         : {sum[SUM_BITS-1], {(ACC_BITS - 1){!sum[SUM_BITS-1]}}};

   nea_ram #(
      .WIDTH (ACC_BITS),
      .DEPTH (DEPTH)
   ) u_nea_ram (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= TERMS_RESET;
         wr_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            active_ff <= csr_data;
         end
         wr_pend_ff <= cmd.issue && cmd.update;
         if (wr_pend_ff) begin
            valid_ff[wr_addr_ff] <= 1'b1;
            if (!fits) begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_tuser;
         target_ff <= req_tdata[TARGET_LSB +: SAMPLE_BITS];
         rd_row_ff <= req_tdata[ROW_LSB +: READ_ROW_BITS];
         rd_col_ff <= req_tdata[COL_LSB +: READ_COL_BITS];
         value_ff  <= '0;
         for (int i = 0; i < MAX_TERMS; i++) begin
            if (TERMS_BITS'(i) < eff_terms) begin
               row_line_ff[i] <= req_tdata[i * SAMPLE_BITS +: SAMPLE_BITS];
               col_line_ff[i] <= req_tdata[i * SAMPLE_BITS +: SAMPLE_BITS];
            end else begin
               row_line_ff[i] <= '0;
               col_line_ff[i] <= '0;
            end
         end
      end else begin
         // rotate the column line per Gram entry, the row line per moment entry
         if (cmd.issue && cmd.update) begin
            if (is_mom) begin
               for (int i = 0; i < MAX_TERMS - 1; i++) begin
                  row_line_ff[i] <= row_line_ff[i + 1];
               end
               row_line_ff[MAX_TERMS - 1] <= row_line_ff[0];
            end else begin
               for (int i = 0; i < MAX_TERMS - 1; i++) begin
                  col_line_ff[i] <= col_line_ff[i + 1];
               end
               col_line_ff[MAX_TERMS - 1] <= col_line_ff[0];
            end
         end
         if (cmd.take_read) begin
            value_ff <= acc;
         end
      end
      if (cmd.issue) begin
         prod_ff    <= prod;
         wr_addr_ff <= addr;
         rd_vld_ff  <= in_range && valid_ff[addr];
      end
      if (cmd.load_out) begin
         rsp_value_ff <= value_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign status.kind     = kind_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'($unsigned(rsp_value_ff));
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

`default_nettype wire

// File: rtl/core/nea_checker.sv
// Port-level checks of the normal equation accumulator, bound to the top level.
// Depends on nea_pkg, assert_macros.svh, normal_equation_accumulator.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nea_checker
   import nea_pkg::*;
#(
   parameter  int ACC_BITS      = ACC_BITS_DEFAULT,
   localparam int RSP_DATA_BITS = ((ACC_BITS + 7) / 8) * 8
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic [0:0]               rsp_tuser
);

   logic [2:0] pend_ff, pend_in;
   logic       seen_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({req_take, rsp_take})
         2'b10:   pend_in = pend_ff + 3'd1;
         2'b01:   pend_in = pend_ff - 3'd1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         seen_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (rsp_take && rsp_tuser[0]) begin
            seen_ff <= 1'b1;
         end
      end
   end

   `NEA_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result item changed while stalled")
   `NEA_ASSERT(a_ovf_sticky, rsp_tvalid && seen_ff |-> rsp_tuser[0], "overflow flag dropped after it was reported")
   `NEA_ASSERT(a_no_extra_rsp, rsp_tvalid |-> pend_ff != 3'd0, "result item without an accepted input item")
   `NEA_ASSERT(a_pend_bound, pend_ff <= 3'd2, "more than two items in flight")

endmodule

bind normal_equation_accumulator nea_checker #(
   .ACC_BITS (ACC_BITS)
) u_nea_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: sim/tb_normal_equation_accumulator.sv
`timescale 1ns / 1ps
// Self-checking bench for normal_equation_accumulator: a directed table of rows and reads,
// then random phases at several term counts, scored against an in-bench copy of the stores.
// Depends on nea_pkg and the RTL of the block only.

module tb_normal_equation_accumulator;
   import nea_pkg::*;

   localparam int SAMPLE_BITS = SAMPLE_BITS_DEFAULT;
   localparam int ACC_BITS    = ACC_BITS_DEFAULT;
   localparam int TERM_SLOTS  = MAX_TERMS_DEFAULT;
   localparam int REQ_BITS    =
      ((REG_COUNT * SAMPLE_BITS + SAMPLE_BITS + READ_ROW_BITS + READ_COL_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = ((ACC_BITS + 7) / 8) * 8;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   localparam longint ACC_HI = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
   localparam longint ACC_LO = -ACC_HI - 64'sd1;

   localparam int PHASE_ITEMS  = 190;
   localparam int HOLD_CYCLES  = 600;   // long receiver hold-off, fills the block
   localparam int SETTLE_CYCLES = 8;    // pause before a register write
   localparam int DRAIN_CYCLES = 100;   // quiet tail after the last result
   localparam int STALL_LIMIT  = 5000;  // cycles without any handshake

   localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [ACC_BITS-1:0]    FULL_SQUARE = ACC_BITS'(64'd1 << 30);

   // One observation row or read request as it travels on the req channel
   typedef struct packed {
      logic [CMD_BITS-1:0]                   cmd;
      logic [REG_COUNT-1:0][SAMPLE_BITS-1:0] x;
      logic [SAMPLE_BITS-1:0]                t;
      logic [READ_ROW_BITS-1:0]              row;
      logic [READ_COL_BITS-1:0]              col;
   } row_item;

   // Directed row: when fixed is set, value is the typed-in read_value
   typedef struct packed {
      row_item             item;
      logic                fixed;
      logic [ACC_BITS-1:0] value;
   } table_row;

   typedef struct packed {
      logic [ACC_BITS-1:0] value;
      logic                ovf;
   } result_entry;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_BITS-1:0]     req_tdata = '0;
   logic [CMD_BITS-1:0]     req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]     rsp_tdata;
   logic [0:0]              rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [TERMS_BITS-1:0]   csr_data = TERMS_RESET;

   // Bench copy of the block state
   longint                  gram_model [TERM_SLOTS][TERM_SLOTS];
   longint                  moment_model [TERM_SLOTS];
   bit                      overflow_model = 1'b0;
   logic [TERMS_BITS-1:0]   terms_model = TERMS_RESET;

   result_entry             awaited_results [$];
   int                      failures = 0;
   int                      idle_cycles = 0;
   bit                      quiet = 1'b0;          // no idling on either side while set
   bit                      hold_pending = 1'b0;   // ask the receiver for one long hold-off

   localparam int DIRECTED_ROWS = 23;
   table_row directed [DIRECTED_ROWS] = '{
      // after reset every entry reads zero
      '{'{CMD_READ, '0, '0, 3'd0, 4'd0}, 1'b1, '0},
      '{'{CMD_READ, '0, '0, 3'd7, MOMENT_COL}, 1'b1, '0},
      // columns past the moment entry read zero
      '{'{CMD_READ, '0, '0, 3'd5, 4'd9}, 1'b1, '0},
      '{'{CMD_READ, '0, '0, 3'd7, 4'd15}, 1'b1, '0},
      // unused command changes nothing
      '{'{CMD_UNUSED, {REG_COUNT{S_MAX}}, S_MAX, 3'd1, 4'd1}, 1'b1, '0},
      // full negative row: every product is 2^30
      '{'{CMD_ADD, {REG_COUNT{S_MIN}}, S_MIN, 3'd0, 4'd0}, 1'b1, '0},
      '{'{CMD_READ, '0, '0, 3'd3, 4'd5}, 1'b1, FULL_SQUARE},
      '{'{CMD_READ, '0, '0, 3'd7, 4'd7}, 1'b1, FULL_SQUARE},
      '{'{CMD_READ, '0, '0, 3'd6, MOMENT_COL}, 1'b1, FULL_SQUARE},
      // remove it again
      '{'{CMD_SUB, {REG_COUNT{S_MIN}}, S_MIN, 3'd0, 4'd0}, 1'b1, '0},
      '{'{CMD_READ, '0, '0, 3'd3, 4'd5}, 1'b1, '0},
      '{'{CMD_READ, '0, '0, 3'd0, MOMENT_COL}, 1'b1, '0},
      // mixed extremes, scored by the model
      '{'{CMD_ADD, {REG_COUNT{S_MAX}}, S_MIN, 3'd7, 4'd15}, 1'b1, '0},
      '{'{CMD_READ, '0, '0, 3'd0, 4'd0}, 1'b0, '0},
      '{'{CMD_READ, '0, '0, 3'd2, MOMENT_COL}, 1'b0, '0},
      '{'{CMD_ADD, {(REG_COUNT / 2){S_MIN, S_MAX}}, S_MAX, 3'd0, 4'd0}, 1'b1, '0},
      '{'{CMD_READ, '0, '0, 3'd0, 4'd1}, 1'b0, '0},
      '{'{CMD_READ, '0, '0, 3'd1, 4'd1}, 1'b0, '0},
      '{'{CMD_SUB, {16'sd8, 16'sd7, 16'sd6, 16'sd5, 16'sd4, 16'sd3, 16'sd2, 16'sd1},
         16'hffff, 3'd0, 4'd0}, 1'b1, '0},
      '{'{CMD_READ, '0, '0, 3'd7, MOMENT_COL}, 1'b0, '0},
      '{'{CMD_READ, '0, '0, 3'd4, 4'd2}, 1'b0, '0},
      '{'{CMD_UNUSED, '0, '0, 3'd0, 4'd0}, 1'b1, '0},
      '{'{CMD_READ, '0, '0, 3'd0, 4'd0}, 1'b0, '0}
   };

   normal_equation_accumulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   initial begin
      foreach (gram_model[r, c]) gram_model[r][c] = 0;
      foreach (moment_model[r]) moment_model[r] = 0;
   end

   // Clamp acc + p to the accumulator range and raise the sticky flag on a clamp.
   // A full-scale row adds at most 2^30 per entry, so the 48-bit limit needs about
   // 2^17 such rows; the flag is modeled but stays low in a run of this length.
   function automatic longint saturating_sum(longint acc, longint p);
      if (p > 0 && acc > ACC_HI - p) begin
         overflow_model = 1'b1;
         return ACC_HI;
      end
      if (p < 0 && acc < ACC_LO - p) begin
         overflow_model = 1'b1;
         return ACC_LO;
      end
      return acc + p;
   endfunction

   // Fold one accepted item into the bench stores; return the read_value it yields
   function automatic logic [ACC_BITS-1:0] fold_row(row_item it);
      longint              xs [TERM_SLOTS];
      longint              tv;
      longint              p;
      int                  terms;
      int                  r;
      int                  c;
      logic [ACC_BITS-1:0] value;
      // term counts above the store size act as the full size
      terms = (terms_model > TERM_SLOTS) ? TERM_SLOTS : int'(terms_model);
      tv    = longint'($signed(it.t));
      value = '0;
      for (r = 0; r < TERM_SLOTS; r++)
         xs[r] = (r < terms) ? longint'($signed(it.x[r])) : 64'sd0;
      if (it.cmd == CMD_ADD || it.cmd == CMD_SUB) begin
         for (r = 0; r < TERM_SLOTS; r++) begin
            for (c = 0; c < TERM_SLOTS; c++) begin
               p = xs[r] * xs[c];
               gram_model[r][c] = saturating_sum(gram_model[r][c], (it.cmd == CMD_SUB) ? -p : p);
            end
            p = xs[r] * tv;
            moment_model[r] = saturating_sum(moment_model[r], (it.cmd == CMD_SUB) ? -p : p);
         end
      end else if (it.cmd == CMD_READ) begin
         if (it.col < MOMENT_COL)
            value = gram_model[it.row][it.col][ACC_BITS-1:0];
         else if (it.col == MOMENT_COL)
            value = moment_model[it.row][ACC_BITS-1:0];
      end
      return value;
   endfunction

   // Bias samples toward the extremes and zero, otherwise full random
   function automatic logic [SAMPLE_BITS-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return S_MIN;
         1: return S_MAX;
         2: return '0;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic row_item draw_item();
      row_item it;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         it.cmd = CMD_ADD;
      else if (pick < 65)
         it.cmd = CMD_SUB;
      else if (pick < 95)
         it.cmd = CMD_READ;
      else
         it.cmd = CMD_UNUSED;
      for (int r = 0; r < REG_COUNT; r++)
         it.x[r] = draw_sample();
      it.t   = draw_sample();
      it.row = READ_ROW_BITS'($urandom);
      it.col = ($urandom_range(0, 6) == 0) ? READ_COL_BITS'($urandom_range(9, 15))
                                            : READ_COL_BITS'($urandom_range(0, 8));
      return it;
   endfunction

   // Offer one item after a random gap, hold it until accepted, then predict its result
   task automatic offer_item(input row_item it, input logic fixed,
                             input logic [ACC_BITS-1:0] fixed_value);
      int                  gap;
      logic [ACC_BITS-1:0] value;
      result_entry         e;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= REQ_BITS'({it.col, it.row, it.t, it.x});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      value   = fold_row(it);
      e.value = fixed ? fixed_value : value;
      e.ovf   = overflow_model;
      awaited_results.push_back(e);
   endtask

   task automatic write_terms(input logic [TERMS_BITS-1:0] terms);
      csr_valid <= 1'b1;
      csr_data  <= terms;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      terms_model = terms;
   endtask

   // Drain, reprogram the term count while idle, then stream random items
   task automatic run_phase(input logic [TERMS_BITS-1:0] terms, input bit calm,
                            input bit with_hold);
      // hold the sender until every awaited result has come back
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_terms(terms);
      quiet = calm;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (with_hold && n == PHASE_ITEMS / 4)
            hold_pending = 1'b1;
         offer_item(draw_item(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed part runs at the reset term count
      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer_item(directed[i].item, directed[i].fixed, directed[i].value);
      req_tvalid <= 1'b0;
      // sweep the term count: minimum, full with a long hold-off, zero, out-of-range
      // values, and quiet stretches with back-to-back items on both sides
      run_phase(4'd1, 1'b0, 1'b0);
      run_phase(4'd8, 1'b0, 1'b1);
      run_phase(4'd0, 1'b0, 1'b0);
      run_phase(4'd15, 1'b0, 1'b0);
      run_phase(4'd3, 1'b1, 1'b0);
      run_phase(4'd9, 1'b0, 1'b0);
      run_phase(4'd6, 1'b0, 1'b0);
      run_phase(4'd8, 1'b1, 1'b0);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Receiver: random stall per result, plus one long hold-off on request
   initial begin : result_sink
      int stall;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = quiet ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Score each accepted result against the oldest awaited one
   always @(posedge clock) begin : scoreboard
      result_entry e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $error("result with nothing awaited: read_value %0h overflow %0b",
                   rsp_tdata[ACC_BITS-1:0], rsp_tuser[0]);
            failures++;
         end else begin
            e = awaited_results.pop_front();
            if (rsp_tdata[ACC_BITS-1:0] !== e.value) begin
               $error("read_value expected %0h actual %0h", e.value, rsp_tdata[ACC_BITS-1:0]);
               failures++;
            end
            if (rsp_tuser[0] !== e.ovf) begin
               $error("overflow expected %0b actual %0b", e.ovf, rsp_tuser[0]);
               failures++;
            end
         end
      end
   end

   // Watchdog: end the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule
